@@ sv/bpd_pkg.sv @@
package bpd_pkg;

    // Fixed field widths
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int LIMIT_W    = 8;
    localparam int TIMEOUT_W  = 17;
    localparam int ELAPSED_W  = 12;
    localparam int COUNT_W    = 8;
    localparam int PHASE_W    = 2;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_BEEP     = 3'd0,
        CFG_MAX_BEEP     = 3'd1,
        CFG_MAX_GAP      = 3'd2,
        CFG_BEEPS_NEEDED = 3'd3,
        CFG_TIMEOUT      = 3'd4
    } cfg_idx_t;

    // Register values after reset
    localparam logic [LIMIT_W-1:0]   MIN_BEEP_RST     = 8'd3;
    localparam logic [LIMIT_W-1:0]   MAX_BEEP_RST     = 8'd15;
    localparam logic [LIMIT_W-1:0]   MAX_GAP_RST      = 8'd30;
    localparam logic [LIMIT_W-1:0]   BEEPS_NEEDED_RST = 8'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 17'd10999;

    // Phase codes as reported on the result channel
    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_BEEP = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_GAP  = 2'd2;

    // Pattern machine states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BEEP = 3'b010,
        ST_GAP  = 3'b100
    } state_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]   min_beep_frames;
        logic [LIMIT_W-1:0]   max_beep_frames;
        logic [LIMIT_W-1:0]   max_gap_frames;
        logic [LIMIT_W-1:0]   beeps_needed;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic               alarm_detected;
        logic [COUNT_W-1:0] beeps_seen;
        logic [PHASE_W-1:0] phase;
    } result_t;

endpackage

@@ sv/bpd_cfg.sv @@
module bpd_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpd_pkg::CFG_W-1:0]          cfg_data,
    output bpd_pkg::cfg_t                      cfg
);

    bpd_pkg::cfg_t cfg_reg;

    // Write one register per request; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_beep_frames <= bpd_pkg::MIN_BEEP_RST;
            cfg_reg.max_beep_frames <= bpd_pkg::MAX_BEEP_RST;
            cfg_reg.max_gap_frames  <= bpd_pkg::MAX_GAP_RST;
            cfg_reg.beeps_needed    <= bpd_pkg::BEEPS_NEEDED_RST;
            cfg_reg.timeout_ms      <= bpd_pkg::TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bpd_pkg::CFG_MIN_BEEP: begin
                    cfg_reg.min_beep_frames <= cfg_data[bpd_pkg::LIMIT_W-1:0];
                end
                bpd_pkg::CFG_MAX_BEEP: begin
                    cfg_reg.max_beep_frames <= cfg_data[bpd_pkg::LIMIT_W-1:0];
                end
                bpd_pkg::CFG_MAX_GAP: begin
                    cfg_reg.max_gap_frames <= cfg_data[bpd_pkg::LIMIT_W-1:0];
                end
                bpd_pkg::CFG_BEEPS_NEEDED: begin
                    cfg_reg.beeps_needed <= cfg_data[bpd_pkg::LIMIT_W-1:0];
                end
                bpd_pkg::CFG_TIMEOUT: begin
                    cfg_reg.timeout_ms <= cfg_data[bpd_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/bpd_fsm.sv @@
module bpd_fsm #(
    parameter int FRAME_COUNT_BITS = 9,
    parameter int ELAPSED_BITS     = 17
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic                           tone,
    input  logic [bpd_pkg::ELAPSED_W-1:0]  elapsed,
    input  bpd_pkg::cfg_t                  cfg,
    output bpd_pkg::result_t               res_next,
    output logic [bpd_pkg::COUNT_W-1:0]    beeps_cur
);

    localparam int SUM_W   = ELAPSED_BITS + 1;
    localparam int CMP_W   = (ELAPSED_BITS > bpd_pkg::TIMEOUT_W) ?
                             ELAPSED_BITS : bpd_pkg::TIMEOUT_W;
    localparam int RUN_CW  = (FRAME_COUNT_BITS > bpd_pkg::LIMIT_W) ?
                             FRAME_COUNT_BITS : bpd_pkg::LIMIT_W;

    bpd_pkg::state_t               phase_reg, phase_next;
    logic [FRAME_COUNT_BITS-1:0]   run_reg, run_next;
    logic [bpd_pkg::COUNT_W-1:0]   total_reg, total_next;
    logic [ELAPSED_BITS-1:0]       acc_reg, acc_next;

    logic [SUM_W-1:0]              acc_sum;
    logic [ELAPSED_BITS-1:0]       acc_sat;
    logic                          timed_out;
    bpd_pkg::state_t               phase_a;
    logic [FRAME_COUNT_BITS-1:0]   run_a, run_inc;
    logic [bpd_pkg::COUNT_W-1:0]   total_a, total_inc;

    // Accumulate elapsed time, saturating, and check the timeout
    always_comb begin
        acc_sum   = SUM_W'({1'b0, acc_reg}) + SUM_W'(elapsed);
        acc_sat   = acc_sum[ELAPSED_BITS] ? '1 : acc_sum[ELAPSED_BITS-1:0];
        timed_out = CMP_W'(acc_sat) > CMP_W'(cfg.timeout_ms);
        phase_a   = timed_out ? bpd_pkg::ST_IDLE : phase_reg;
        run_a     = timed_out ? '0 : run_reg;
        total_a   = timed_out ? '0 : total_reg;
        run_inc   = (run_a == '1) ? run_a : run_a + 1'b1;
        total_inc = (total_a == '1) ? total_a : total_a + 1'b1;
    end

    // Advance the idle, beep and gap machine
    always_comb begin
        phase_next = phase_a;
        run_next   = run_a;
        total_next = total_a;
        acc_next   = acc_sat;
        case (phase_a)
            bpd_pkg::ST_BEEP: begin
                if (tone) begin
                    run_next = run_inc;
                    if (RUN_CW'(run_inc) > RUN_CW'(cfg.max_beep_frames)) begin
                        phase_next = bpd_pkg::ST_IDLE;
                        run_next   = '0;
                        total_next = '0;
                    end
                end else if (RUN_CW'(run_a) >= RUN_CW'(cfg.min_beep_frames)) begin
                    phase_next = bpd_pkg::ST_GAP;
                    run_next   = '0;
                    total_next = total_inc;
                    acc_next   = '0;
                end else begin
                    phase_next = bpd_pkg::ST_IDLE;
                    run_next   = '0;
                    total_next = '0;
                end
            end
            bpd_pkg::ST_GAP: begin
                if (tone) begin
                    phase_next = bpd_pkg::ST_BEEP;
                    run_next   = FRAME_COUNT_BITS'(1);
                    acc_next   = '0;
                end else begin
                    run_next = run_inc;
                    if (RUN_CW'(run_inc) > RUN_CW'(cfg.max_gap_frames)) begin
                        phase_next = bpd_pkg::ST_IDLE;
                        run_next   = '0;
                        total_next = '0;
                    end
                end
            end
            default: begin
                phase_next = bpd_pkg::ST_IDLE;
                if (tone) begin
                    phase_next = bpd_pkg::ST_BEEP;
                    run_next   = FRAME_COUNT_BITS'(1);
                    acc_next   = '0;
                end
            end
        endcase
    end

    // Hold state between frames
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bpd_pkg::ST_IDLE;
            run_reg   <= '0;
            total_reg <= '0;
            acc_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
            total_reg <= total_next;
            acc_reg   <= acc_next;
        end
    end

    // Form the result of this frame
    always_comb begin
        res_next.alarm_detected = total_next >= cfg.beeps_needed;
        res_next.beeps_seen     = total_next;
        case (phase_next)
            bpd_pkg::ST_BEEP: res_next.phase = bpd_pkg::PHASE_BEEP;
            bpd_pkg::ST_GAP:  res_next.phase = bpd_pkg::PHASE_GAP;
            default:          res_next.phase = bpd_pkg::PHASE_IDLE;
        endcase
    end

    assign beeps_cur = total_reg;

endmodule

@@ sv/beep_pattern_detector.sv @@
// Channel    | Ports                                   | Direction
// -----------+-----------------------------------------+----------
// config     | cfg_wr_en, cfg_index, cfg_data          | in
// frame in   | s_valid/s_ready, s_tone_present, s_elapsed_ms | in
// result out | m_valid/m_ready, m_alarm_detected, m_beeps_seen, m_phase | out
//
// One frame request per cycle while s_ready is high; a taken request waits in the
// input register, then the machine update loads the result register and raises
// m_valid once the result slot is free or being read.
// Reset (aresetn low at a clock edge) clears the machine to idle and loads the
// register reset values. A stalled result holds while the input register
// still takes the next request; s_ready drops only when both stages are full.
module beep_pattern_detector #(
    parameter int FRAME_COUNT_BITS = 9,
    parameter int ELAPSED_BITS     = 17
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpd_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_tone_present,
    input  logic [bpd_pkg::ELAPSED_W-1:0]  s_elapsed_ms,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_alarm_detected,
    output logic [bpd_pkg::COUNT_W-1:0]    m_beeps_seen,
    output logic [bpd_pkg::PHASE_W-1:0]    m_phase
);

    bpd_pkg::cfg_t                 cfg;
    bpd_pkg::result_t              res_next;
    bpd_pkg::result_t              res_reg;
    logic [bpd_pkg::COUNT_W-1:0]   beeps_cur;

    logic                          in_valid_reg, in_valid_next;
    logic                          tone_reg;
    logic [bpd_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          s_accept;
    logic                          advance;

    bpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpd_fsm #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS),
        .ELAPSED_BITS     (ELAPSED_BITS)
    ) u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .tone      (tone_reg),
        .elapsed   (elapsed_reg),
        .cfg       (cfg),
        .res_next  (res_next),
        .beeps_cur (beeps_cur)
    );

    // Move the held request into the machine when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture request and result payloads
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tone_reg    <= s_tone_present;
            elapsed_reg <= s_elapsed_ms;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_alarm_detected = res_reg.alarm_detected;
    assign m_beeps_seen     = res_reg.beeps_seen;
    assign m_phase          = res_reg.phase;

`ifndef ASSERT_OFF
    // A frame handed to the machine shows up as a result next cycle
    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced frame did not produce a result");

    // An idle result always carries a cleared beep count
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_phase == bpd_pkg::PHASE_IDLE)) |-> (m_beeps_seen == '0))
        else $error("idle result with nonzero beep count");

    // The beep count clears, holds or steps by one per frame
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> ((res_next.beeps_seen == '0) ||
                     (res_next.beeps_seen == beeps_cur) ||
                     (res_next.beeps_seen == bpd_pkg::COUNT_W'(beeps_cur + 1'b1))))
        else $error("beep count jumped");
`endif

endmodule

@@ bench/tb_beep_pattern_detector.sv @@
`timescale 1ns / 100ps

typedef struct packed {
    logic                          tone;
    logic [bpd_pkg::ELAPSED_W-1:0] elapsed;
} frame_t;

// Tracks the pattern machine and the results it must produce, in request order
class beep_scoreboard;
    localparam logic [8:0]  RUN_MAX = 9'h1FF;
    localparam logic [16:0] ACC_MAX = 17'h1FFFF;

    bpd_pkg::cfg_t               cfg;
    logic [bpd_pkg::PHASE_W-1:0] phase;
    logic [8:0]                  frame_run;
    logic [bpd_pkg::COUNT_W-1:0] beep_total;
    logic [16:0]                 since_edge_ms;
    bpd_pkg::result_t            pending_results[$];
    int                          mismatches;

    function new();
        cfg.min_beep_frames = bpd_pkg::MIN_BEEP_RST;
        cfg.max_beep_frames = bpd_pkg::MAX_BEEP_RST;
        cfg.max_gap_frames  = bpd_pkg::MAX_GAP_RST;
        cfg.beeps_needed    = bpd_pkg::BEEPS_NEEDED_RST;
        cfg.timeout_ms      = bpd_pkg::TIMEOUT_RST;
        phase         = bpd_pkg::PHASE_IDLE;
        frame_run     = '0;
        beep_total    = '0;
        since_edge_ms = '0;
        mismatches    = 0;
    endfunction

    // Mirror a register write; spare indexes are dropped
    function void load_reg(logic [bpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpd_pkg::CFG_W-1:0] data);
        case (idx)
            bpd_pkg::CFG_MIN_BEEP:     cfg.min_beep_frames = data[bpd_pkg::LIMIT_W-1:0];
            bpd_pkg::CFG_MAX_BEEP:     cfg.max_beep_frames = data[bpd_pkg::LIMIT_W-1:0];
            bpd_pkg::CFG_MAX_GAP:      cfg.max_gap_frames  = data[bpd_pkg::LIMIT_W-1:0];
            bpd_pkg::CFG_BEEPS_NEEDED: cfg.beeps_needed    = data[bpd_pkg::LIMIT_W-1:0];
            bpd_pkg::CFG_TIMEOUT:      cfg.timeout_ms      = data[bpd_pkg::TIMEOUT_W-1:0];
            default: ;
        endcase
    endfunction

    function void clear_pattern();
        phase      = bpd_pkg::PHASE_IDLE;
        frame_run  = '0;
        beep_total = '0;
    endfunction

    function void start_beep();
        phase         = bpd_pkg::PHASE_BEEP;
        frame_run     = 9'd1;
        since_edge_ms = '0;
    endfunction

    // Advance the machine by one accepted frame and queue the result it yields
    function void note_frame(frame_t f);
        logic [17:0]      sum;
        bpd_pkg::result_t r;
        sum = {1'b0, since_edge_ms} + {6'b0, f.elapsed};
        since_edge_ms = sum[17] ? ACC_MAX : sum[16:0];

        // timeout is checked ahead of the transition
        if (since_edge_ms > cfg.timeout_ms) clear_pattern();

        case (phase)
            bpd_pkg::PHASE_BEEP: begin
                if (f.tone) begin
                    if (frame_run != RUN_MAX) frame_run = frame_run + 1'b1;
                    if (frame_run > cfg.max_beep_frames) clear_pattern();
                end else if (frame_run >= cfg.min_beep_frames) begin
                    if (beep_total != 8'hFF) beep_total = beep_total + 1'b1;
                    phase         = bpd_pkg::PHASE_GAP;
                    frame_run     = '0;
                    since_edge_ms = '0;
                end else begin
                    clear_pattern();
                end
            end
            bpd_pkg::PHASE_GAP: begin
                if (f.tone) begin
                    start_beep();
                end else begin
                    if (frame_run != RUN_MAX) frame_run = frame_run + 1'b1;
                    if (frame_run > cfg.max_gap_frames) clear_pattern();
                end
            end
            default: begin
                phase = bpd_pkg::PHASE_IDLE;
                if (f.tone) start_beep();
            end
        endcase

        r.alarm_detected = (beep_total >= cfg.beeps_needed);
        r.beeps_seen     = beep_total;
        r.phase          = phase;
        pending_results.push_back(r);
    endfunction

    // Compare one delivered result against the oldest one queued
    function void check_result(bpd_pkg::result_t got);
        bpd_pkg::result_t want;
        if (pending_results.size() == 0) begin
            $error("result with nothing pending: alarm %0d beeps %0d phase %0d",
                   got.alarm_detected, got.beeps_seen, got.phase);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (got.alarm_detected !== want.alarm_detected) begin
            $error("alarm_detected: expected %0d, got %0d",
                   want.alarm_detected, got.alarm_detected);
            mismatches++;
        end
        if (got.beeps_seen !== want.beeps_seen) begin
            $error("beeps_seen: expected %0d, got %0d", want.beeps_seen, got.beeps_seen);
            mismatches++;
        end
        if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            mismatches++;
        end
    endfunction
endclass

module tb_beep_pattern_detector;

    localparam logic [bpd_pkg::CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd5;
    localparam logic [bpd_pkg::CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
    logic [bpd_pkg::CFG_W-1:0]     cfg_data       = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic                          s_tone_present = 1'b0;
    logic [bpd_pkg::ELAPSED_W-1:0] s_elapsed_ms   = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic                          m_alarm_detected;
    logic [bpd_pkg::COUNT_W-1:0]   m_beeps_seen;
    logic [bpd_pkg::PHASE_W-1:0]   m_phase;

    beep_scoreboard sb;
    frame_t         frame_q[$];
    frame_t         offered;
    bit             offering       = 1'b0;
    int             frames_queued  = 0;
    int             burst_left     = 0;
    int             gap_left       = 0;
    bit             want_long_hold = 1'b0;
    bit             long_hold_done = 1'b0;
    int             hold_left      = 0;
    int             stall_left     = 0;
    int             ready_left     = 0;

    beep_pattern_detector uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_tone_present   (s_tone_present),
        .s_elapsed_ms     (s_elapsed_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_alarm_detected (m_alarm_detected),
        .m_beeps_seen     (m_beeps_seen),
        .m_phase          (m_phase)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Feed frame requests in bursts with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sb.note_frame(offered);
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (frame_q.size() != 0) begin
                    offered  = frame_q.pop_front();
                    offering = 1'b1;
                    s_valid        <= 1'b1;
                    s_tone_present <= offered.tone;
                    s_elapsed_ms   <= offered.elapsed;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = int'($urandom_range(1, 30));
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0
                                                                 : int'($urandom_range(1, 8));
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Take results on a stall pattern of their own, with one long hold-off
    always @(posedge aclk) begin : take_results
        bpd_pkg::result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_alarm_detected, m_beeps_seen, m_phase};
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (want_long_hold && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = 80;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (ready_left > 0) begin
                    ready_left--;
                end else begin
                    ready_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                                              : int'($urandom_range(0, 6));
                    stall_left = int'($urandom_range(1, 4));
                end
            end
        end
    end

    function automatic void push_frame(logic tone, int el);
        frame_t f;
        f.tone    = tone;
        f.elapsed = bpd_pkg::ELAPSED_W'(el);
        frame_q.push_back(f);
        frames_queued++;
    endfunction

    // Mostly small steps, now and then anything up to the field's maximum
    function automatic int pick_elapsed(int el_cap);
        return ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 4095))
                                            : int'($urandom_range(0, el_cap));
    endfunction

    task automatic write_reg(logic [bpd_pkg::CFG_IDX_W-1:0] idx,
                             logic [bpd_pkg::CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.load_reg(idx, data);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(int min_b, int max_b, int max_g, int needed, int tmo);
        write_reg(bpd_pkg::CFG_MIN_BEEP, bpd_pkg::CFG_W'(min_b));
        write_reg(bpd_pkg::CFG_MAX_BEEP, bpd_pkg::CFG_W'(max_b));
        write_reg(bpd_pkg::CFG_MAX_GAP, bpd_pkg::CFG_W'(max_g));
        write_reg(bpd_pkg::CFG_BEEPS_NEEDED, bpd_pkg::CFG_W'(needed));
        write_reg(bpd_pkg::CFG_TIMEOUT, bpd_pkg::CFG_W'(tmo));
    endtask

    // Hold until every request is taken and every result has come back
    task automatic drain();
        while (frame_q.size() != 0 || offering || sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Queue beep/gap patterns fitted to the current limits, mixed with noise
    task automatic queue_patterns(int n_items, int el_cap, int noise_pct);
        int stop_at;
        int lo;
        int hi;
        int len;
        int gl;
        int gcap;
        stop_at = frames_queued + n_items;
        while (frames_queued < stop_at) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                repeat ($urandom_range(1, 4))
                    push_frame(1'($urandom_range(0, 1)), pick_elapsed(el_cap));
            end else begin
                lo   = (sb.cfg.min_beep_frames == 0) ? 1 : int'(sb.cfg.min_beep_frames);
                hi   = (int'(sb.cfg.max_beep_frames) < lo) ? lo
                                                           : int'(sb.cfg.max_beep_frames);
                gcap = int'(sb.cfg.max_gap_frames);
                len  = int'($urandom_range(lo, hi));
                case ($urandom_range(0, 9))
                    0: len = hi + 1;
                    1: len = lo - 1;
                    default: ;
                endcase
                repeat (len) push_frame(1'b1, pick_elapsed(el_cap));
                gl = int'($urandom_range(1, (gcap > 8) ? 8 : (gcap == 0) ? 1 : gcap));
                if ($urandom_range(0, 9) == 0 && gcap < 20)
                    gl = gcap + 1;
                repeat (gl) push_frame(1'b0, pick_elapsed(el_cap));
            end
        end
    endtask

    initial begin : stimulus
        int lo;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset limits: a beep that runs past the reset timeout clears to idle
        push_frame(1'b1, 4095);
        push_frame(1'b1, 4095);
        push_frame(1'b1, 4095);
        push_frame(1'b0, 4095);
        drain();

        set_limits(2, 3, 2, 2, 8000);
        // timeout mid-beep, then idle silent frame
        push_frame(1'b1, 4095);
        push_frame(1'b1, 4095);
        push_frame(1'b0, 4095);
        // beep too short
        push_frame(1'b1, 0);
        push_frame(1'b0, 0);
        // beep too long
        repeat (4) push_frame(1'b1, 0);
        // valid beep, then gap too long
        push_frame(1'b1, 1);
        push_frame(1'b1, 1);
        repeat (4) push_frame(1'b0, 1);
        // two valid beeps raise the alarm, which holds into the next beep
        repeat (2) begin
            push_frame(1'b1, 0);
            push_frame(1'b1, 0);
            push_frame(1'b0, 0);
        end
        push_frame(1'b1, 0);
        drain();

        // Reset limits again; stall the result side long and pause the feed once
        set_limits(int'(bpd_pkg::MIN_BEEP_RST), int'(bpd_pkg::MAX_BEEP_RST),
                   int'(bpd_pkg::MAX_GAP_RST), int'(bpd_pkg::BEEPS_NEEDED_RST),
                   int'(bpd_pkg::TIMEOUT_RST));
        want_long_hold = 1'b1;
        queue_patterns(30, 600, 15);
        drain();
        queue_patterns(20, 600, 15);
        drain();

        // Random small limits
        repeat (2) begin
            lo = int'($urandom_range(1, 5));
            set_limits(lo, int'($urandom_range(lo, lo + 6)), int'($urandom_range(1, 8)),
                       int'($urandom_range(1, 5)), int'($urandom_range(300, 20000)));
            queue_patterns(15, int'($urandom_range(20, 400)), 15);
            drain();
        end

        // Spare indexes are ignored; then all limits at zero
        write_reg(SPARE_IDX_LO, '1);
        write_reg(SPARE_IDX_HI, '1);
        set_limits(0, 0, 0, 0, 0);
        queue_patterns(15, 1, 30);
        drain();

        // Top of the range; accumulator pins at its max just past the timeout
        set_limits(255, 255, 1, 1, 131070);
        repeat (33) push_frame(1'b0, 4095);
        queue_patterns(8, 4095, 100);
        drain();

        // Beep count saturation with the timeout at its max
        set_limits(1, 255, 255, 255, 131071);
        repeat (256) begin
            push_frame(1'b1, pick_elapsed(4095));
            push_frame(1'b0, pick_elapsed(4095));
        end
        push_frame(1'b0, pick_elapsed(4095));
        drain();

        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb_beep_pattern_detector: PASS");
        else
            $display("tb_beep_pattern_detector: FAIL");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("tb_beep_pattern_detector: FAIL");
        $finish;
    end

endmodule
